/* rtl/sbfr_pkg.sv */
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared constants and types for the serial bus frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int LAST_POS    = FRAME_BYTES - 1;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int KEPT_BYTES  = 6;
  localparam int KEPT_W      = $clog2(KEPT_BYTES);
  localparam int CHAN_W      = 11;

  localparam logic [7:0] START_BYTE     = 8'h0F;
  localparam logic [7:0] FOOTER_ZERO    = 8'h00;
  localparam logic [3:0] FOOTER_NIBBLE  = 4'h4;

  typedef logic [KEPT_BYTES-1:0][7:0] kept_bytes_t;

  typedef struct packed {
    logic footer_next;  // the next accepted byte closes the frame
    logic frame_ok;     // a good footer is being accepted this cycle
  } fr_status_t;

endpackage

/* rtl/sbfr_framer.sv */
// ----------------------------------------------------------------------------
// sbfr_framer
// Tracks the frame position, keeps frame bytes 1 to 6 and checks the footer.
// ----------------------------------------------------------------------------
module sbfr_framer
  import sbfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output kept_bytes_t kept,
  output fr_status_t  status
);

  logic             in_frame;
  logic [POS_W-1:0] byte_position;
  kept_bytes_t      channel_bytes;
  logic             at_footer;
  logic             footer_good;

  assign at_footer   = in_frame && (byte_position == POS_W'(LAST_POS - 1));
  assign footer_good = (rx_byte == FOOTER_ZERO) || (rx_byte[3:0] == FOOTER_NIBBLE);

  assign status.footer_next = at_footer;
  assign status.frame_ok    = accept && at_footer && footer_good;
  assign kept               = channel_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == START_BYTE) begin
          in_frame      <= 1'b1;
          byte_position <= '0;
        end
      end else if (at_footer) begin
        in_frame <= 1'b0;
      end else begin
        byte_position <= byte_position + POS_W'(1);
      end
    end
  end

  // The byte after position p is frame byte p+1; only frame bytes 1 to 6 are kept.
  always_ff @(posedge clk) begin
    if (accept && in_frame && (byte_position < POS_W'(KEPT_BYTES))) begin
      channel_bytes[byte_position[KEPT_W-1:0]] <= rx_byte;
    end
  end

endmodule

/* rtl/sbfr_unpack.sv */
// ----------------------------------------------------------------------------
// sbfr_unpack
// Unpacks four 11-bit channels from the kept bytes into the result register.
// ----------------------------------------------------------------------------
module sbfr_unpack
  import sbfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  kept_bytes_t       kept,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CHAN_W-1:0] channel_one,
  output logic [CHAN_W-1:0] channel_two,
  output logic [CHAN_W-1:0] channel_three,
  output logic [CHAN_W-1:0] channel_four
);

  logic [CHAN_W-1:0] ch1_next;
  logic [CHAN_W-1:0] ch2_next;
  logic [CHAN_W-1:0] ch3_next;
  logic [CHAN_W-1:0] ch4_next;

  // Channels are packed little-endian starting at frame byte 1 (kept[0]).
  assign ch1_next = {kept[1][2:0], kept[0]};
  assign ch2_next = {kept[2][5:0], kept[1][7:3]};
  assign ch3_next = {kept[4][0], kept[3], kept[2][7:6]};
  assign ch4_next = {kept[5][3:0], kept[4][7:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel_one   <= ch1_next;
      channel_two   <= ch2_next;
      channel_three <= ch3_next;
      channel_four  <= ch4_next;
    end
  end

endmodule

/* rtl/sbus_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// Decodes serial bus frames byte by byte and reports the first four channels.
// ----------------------------------------------------------------------------
//
//   channel   valid       stall       payload
//   -------   ---------   ---------   ------------------------------------------
//   input     in_valid    in_stall    rx_byte
//   output    out_valid   out_stall   channel_one .. channel_four
//
// One byte is accepted every unstalled cycle; a result is registered when its
// footer byte is accepted. Reset clears the frame tracking and the result
// valid; no clearing pass is needed. While a result waits on out_stall, bytes
// keep flowing, and only a footer byte is held off until the result is taken.
// ----------------------------------------------------------------------------
module sbus_frame_receiver
  import sbfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] channel_one,
  output logic [CHAN_W-1:0] channel_two,
  output logic [CHAN_W-1:0] channel_three,
  output logic [CHAN_W-1:0] channel_four
);

  fr_status_t  status;
  kept_bytes_t kept;
  logic        accept;

  assign in_stall = status.footer_next && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  sbfr_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .kept    (kept),
    .status  (status)
  );

  sbfr_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .load          (status.frame_ok),
    .kept          (kept),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .channel_one   (channel_one),
    .channel_two   (channel_two),
    .channel_three (channel_three),
    .channel_four  (channel_four)
  );

endmodule

/* bench/sbus_frame_receiver_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver_test
// Self-checking bench for the frame receiver: streams idle noise, directed
// frames and random frame traffic through the byte channel, predicts the
// four channel values of every frame with a good footer, and compares each
// returned request with the oldest prediction under random idling on both
// sides.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_test;
  import sbfr_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] one;
    logic [CHAN_W-1:0] two;
    logic [CHAN_W-1:0] three;
    logic [CHAN_W-1:0] four;
  } channels_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAN_W-1:0] channel_one;
  logic [CHAN_W-1:0] channel_two;
  logic [CHAN_W-1:0] channel_three;
  logic [CHAN_W-1:0] channel_four;

  // Predictor state.
  bit               frame_open = 1'b0;
  int unsigned      frame_pos = 0;
  logic [7:0]       frame_store [KEPT_BYTES];
  channels_t        pending_channels [$];

  int  error_count = 0;
  bit  input_gaps = 1'b1;
  bit  output_stalls = 1'b1;
  int  stall_left = 0;
  int  frame_bytes_sent = 0;

  sbus_frame_receiver u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_one   (channel_one),
    .channel_two   (channel_two),
    .channel_three (channel_three),
    .channel_four  (channel_four)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sbus_frame_receiver test failed");
    $finish;
  end

  // Advances the frame tracker by one accepted byte and queues the decoded
  // channels when a good footer closes the frame.
  function automatic void track_frame_byte(input logic [7:0] b);
    logic [47:0] word;
    channels_t   chan;
    if (!frame_open) begin
      if (b == START_BYTE) begin
        frame_open = 1'b1;
        frame_pos  = 0;
      end
      return;
    end
    frame_pos++;
    if (frame_pos <= KEPT_BYTES) frame_store[frame_pos-1] = b;
    if (frame_pos < LAST_POS) return;
    frame_open = 1'b0;
    if (b != FOOTER_ZERO && b[3:0] != FOOTER_NIBBLE) return;
    word = {frame_store[5], frame_store[4], frame_store[3],
            frame_store[2], frame_store[1], frame_store[0]};
    chan.one   = word[10:0];
    chan.two   = word[21:11];
    chan.three = word[32:22];
    chan.four  = word[43:33];
    pending_channels.push_back(chan);
  endfunction

  // Leaves in_valid high after the request is taken, so that a following
  // byte sent without a gap goes out back to back.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = input_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_frame_byte(b);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [47:0] chan_bytes, input logic [7:0] footer,
                            input bit fill_with_start);
    send_byte(START_BYTE);
    for (int i = 0; i < KEPT_BYTES; i++) send_byte(chan_bytes[8*i +: 8]);
    for (int i = KEPT_BYTES + 1; i < LAST_POS; i++)
      send_byte(fill_with_start ? START_BYTE : 8'($urandom));
    send_byte(footer);
    frame_bytes_sent += FRAME_BYTES;
  endtask

  task automatic check_channels();
    channels_t want;
    if (pending_channels.size() == 0) begin
      $error("unexpected request: %0d %0d %0d %0d",
             channel_one, channel_two, channel_three, channel_four);
      error_count++;
      return;
    end
    want = pending_channels.pop_front();
    if (channel_one !== want.one) begin
      $error("channel_one expected %0d actual %0d", want.one, channel_one);
      error_count++;
    end
    if (channel_two !== want.two) begin
      $error("channel_two expected %0d actual %0d", want.two, channel_two);
      error_count++;
    end
    if (channel_three !== want.three) begin
      $error("channel_three expected %0d actual %0d", want.three, channel_three);
      error_count++;
    end
    if (channel_four !== want.four) begin
      $error("channel_four expected %0d actual %0d", want.four, channel_four);
      error_count++;
    end
  endtask

  // Result side: after each taken request, draw how long to hold off the next.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_channels();
        stall_left = output_stalls ? $urandom_range(0, 5) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic wait_drained();
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0E);
    send_byte(8'h10);
    send_byte(8'hF0);
    send_byte(8'h04);
    stop_input();
    wait_drained();
  endtask

  task automatic test_footer_forms();
    send_frame({6{8'hFF}}, 8'h00, 1'b0);
    send_frame({6{8'h00}}, 8'h04, 1'b0);
    send_frame(48'hA5_5A_C3_3C_96_69, 8'hF4, 1'b0);
    // Rejected footers: nothing comes out and the next frame still decodes.
    send_frame(48'h12_34_56_78_9A_BC, 8'h05, 1'b0);
    send_frame(48'hFE_DC_BA_98_76_54, 8'h40, 1'b0);
    send_frame(48'h01_02_03_04_05_06, START_BYTE, 1'b0);
    stop_input();
    wait_drained();
  endtask

  task automatic test_start_in_data();
    send_frame({6{START_BYTE}}, 8'h00, 1'b1);
    send_frame(48'h0F_00_0F_FF_0F_80, 8'h74, 1'b1);
    stop_input();
    wait_drained();
  endtask

  // The directed tests and the line noise add roughly 250 bytes on top of
  // the random frames.
  task automatic test_random_traffic();
    logic [47:0] chan_bytes;
    logic [7:0]  footer;
    int          pick;
    int          noise_len;
    frame_bytes_sent = 0;
    while (frame_bytes_sent < 1500) begin
      if ($urandom_range(0, 7) == 0) begin
        input_gaps    = $urandom_range(0, 1);
        output_stalls = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        chan_bytes = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 5))
          0: chan_bytes = '1;
          1: chan_bytes = '0;
          default: ;
        endcase
        case ($urandom_range(0, 2))
          0: footer = FOOTER_ZERO;
          1: footer = {4'($urandom), FOOTER_NIBBLE};
          default: footer = 8'($urandom);
        endcase
        send_frame(chan_bytes, footer, $urandom_range(0, 15) == 0);
      end else begin
        // Line noise; a stray start byte here opens a misaligned frame.
        noise_len = $urandom_range(1, 4);
        repeat (noise_len) send_byte(8'($urandom));
      end
    end
    stop_input();
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_bytes();
    test_footer_forms();
    input_gaps    = 1'b0;
    output_stalls = 1'b0;
    test_start_in_data();
    input_gaps    = 1'b1;
    output_stalls = 1'b1;
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("sbus_frame_receiver test passed");
    end else begin
      $display("sbus_frame_receiver test failed");
    end
    $finish;
  end

endmodule
